// ----- rtl/sstk_pkg.sv -----
// ----------------------------------------------------------------------------
// sstk_pkg
// Shared codes and field layout for the segmented stack core.
// ----------------------------------------------------------------------------
package sstk_pkg;

    // command codes (s_tuser)
    localparam logic [1:0] CMD_PUSH   = 2'd0;
    localparam logic [1:0] CMD_POP    = 2'd1;
    localparam logic [1:0] CMD_POP_AT = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_BAD_INDEX = 2'd2;
    localparam logic [1:0] ST_NO_SLOT   = 2'd3;

    localparam int CMD_W    = 2;
    localparam int DATA_W   = 32;
    localparam int INDEX_W  = 4;
    localparam int STATUS_W = 2;
    localparam int CFG_W    = 5;

    localparam logic [CFG_W-1:0] LIMIT_RESET = 5'd5;

    // input payload: value, segment_index
    localparam int S_PAYLOAD_W = DATA_W + INDEX_W;
    localparam int S_TDATA_W   = ((S_PAYLOAD_W + 7) / 8) * 8;
    localparam int S_PAD_W     = S_TDATA_W - S_PAYLOAD_W;

    // result payload: status, top_value, is_empty
    localparam int M_PAYLOAD_W = STATUS_W + DATA_W + 1;
    localparam int M_TDATA_W   = ((M_PAYLOAD_W + 7) / 8) * 8;
    localparam int M_PAD_W     = M_TDATA_W - M_PAYLOAD_W;

    localparam int M_TOP_LSB   = STATUS_W;
    localparam int M_EMPTY_BIT = STATUS_W + DATA_W;

endpackage

// ----- rtl/segmented_stack_with_pop_at_core.sv -----
// ----------------------------------------------------------------------------
// segmented_stack_with_pop_at_core
// One stack split into segments of bounded size, with push, pop and pop-at.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_*: s_tuser carries the command (push, pop, pop-at),
//   s_tdata the value to push and the segment index for pop-at.
//   Result channel m_*: one transaction per input transaction with status,
//   the new overall top (zero when empty) and the empty flag.
//   cfg_we/cfg_wdata write the segment limit; write only while idle.
// Pipeline and throughput:
//   An accepted transaction waits in the input register, then is applied to
//   the segment table, which also issues the element memory read for the new
//   top into the read stage; the result register that drives m_tvalid loads
//   last. One transaction per cycle is sustained while m_tready is high, set
//   by the single read port of the element memory, read once per transaction.
// Reset:
//   All segments are dropped, all slots free, the limit returns to 5.
//   The element memory keeps its contents; no clearing pass is needed.
// Stall:
//   While m_tready is low the result holds; one more transaction can finish
//   its table update and wait in the read stage, and one more sits in the
//   input register, after which s_tready drops.
// ----------------------------------------------------------------------------
module segmented_stack_with_pop_at_core
    import sstk_pkg::*;
#(
    parameter int MAX_SEGMENTS  = 16,
    parameter int SEGMENT_DEPTH = 16,
    parameter int VALUE_WIDTH   = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,    // [31:0] value, [35:32] segment_index
    input  logic [CMD_W-1:0]     s_tuser,    // [1:0] command

    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,    // [1:0] status, [33:2] top_value,
                                             // [34] is_empty

    input  logic                 cfg_we,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    localparam int SLOT_W  = $clog2(MAX_SEGMENTS);
    localparam int CNT_W   = $clog2(MAX_SEGMENTS + 1);
    localparam int FILL_W  = $clog2(SEGMENT_DEPTH + 1);
    localparam int ENTRIES = MAX_SEGMENTS * SEGMENT_DEPTH;
    localparam int ADDR_W  = $clog2(ENTRIES);
    localparam int LIM_W   = (FILL_W > CFG_W) ? FILL_W : CFG_W;
    localparam int IDX_W   = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

    typedef enum logic [1:0] {
        TOP_ZERO,
        TOP_PUSHED,
        TOP_MEM
    } top_sel_t;

    // ---------------- state ----------------
    logic [CFG_W-1:0]        limit_reg;
    logic [SLOT_W-1:0]       order_reg [MAX_SEGMENTS];
    logic [SLOT_W-1:0]       order_next [MAX_SEGMENTS];
    logic [FILL_W-1:0]       fill_reg [MAX_SEGMENTS];
    logic [FILL_W-1:0]       fill_next [MAX_SEGMENTS];
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [MAX_SEGMENTS-1:0] free_reg, free_next;

    logic [VALUE_WIDTH-1:0]  elem_mem [ENTRIES];

    // input register
    logic                    in_valid_reg;
    logic [CMD_W-1:0]        in_cmd_reg;
    logic [DATA_W-1:0]       in_value_reg;
    logic [INDEX_W-1:0]      in_index_reg;

    // read stage
    logic                    p_valid_reg;
    logic [STATUS_W-1:0]     p_status_reg;
    logic                    p_empty_reg;
    top_sel_t                p_sel_reg;
    logic [VALUE_WIDTH-1:0]  p_pushed_reg;
    logic [VALUE_WIDTH-1:0]  rd_data_reg;

    // result register
    logic                    m_valid_reg;
    logic [STATUS_W-1:0]     m_status_reg;
    logic [DATA_W-1:0]       m_top_reg;
    logic                    m_empty_reg;

    // ---------------- handshake ----------------
    logic out_load, exec_fire, in_fire;

    assign out_load  = p_valid_reg && (!m_valid_reg || m_tready);
    assign exec_fire = in_valid_reg && (!p_valid_reg || out_load);
    assign s_tready  = !in_valid_reg || exec_fire;
    assign in_fire   = s_tvalid && s_tready;

    // ---------------- table update ----------------
    logic [LIM_W-1:0]       eff_lim;
    logic [SLOT_W-1:0]      last_pos, pos, free_slot, tgt_slot, take_slot, new_last;
    logic [FILL_W-1:0]      last_fill, tgt_fill, take_fill, new_fill;
    logic                   need_new, idx_ok, do_write;
    logic [STATUS_W-1:0]    status;
    logic [ADDR_W-1:0]      wr_addr, rd_addr;
    logic [VALUE_WIDTH-1:0] push_val;
    top_sel_t               sel;

    assign push_val = VALUE_WIDTH'(in_value_reg);

    always_comb begin
        eff_lim = LIM_W'(limit_reg);
        if (eff_lim == '0) begin
            eff_lim = LIM_W'(1);
        end
        if (eff_lim > LIM_W'(SEGMENT_DEPTH)) begin
            eff_lim = LIM_W'(SEGMENT_DEPTH);
        end
    end

    // lowest free slot
    always_comb begin
        free_slot = '0;
        for (int s = MAX_SEGMENTS - 1; s >= 0; s--) begin
            if (free_reg[s]) begin
                free_slot = SLOT_W'(s);
            end
        end
    end

    always_comb begin
        last_pos  = SLOT_W'(count_reg - CNT_W'(1));
        last_fill = fill_reg[order_reg[last_pos]];
        idx_ok    = IDX_W'(in_index_reg) < IDX_W'(count_reg);
        pos       = (in_cmd_reg == CMD_POP) ? last_pos : SLOT_W'(in_index_reg);
        take_slot = order_reg[pos];
        take_fill = fill_reg[take_slot] - FILL_W'(1);
        need_new  = (count_reg == '0) || (LIM_W'(last_fill) >= eff_lim);
        tgt_slot  = need_new ? free_slot : order_reg[last_pos];
        tgt_fill  = need_new ? '0 : last_fill;

        order_next = order_reg;
        fill_next  = fill_reg;
        count_next = count_reg;
        free_next  = free_reg;
        status     = ST_OK;
        do_write   = 1'b0;
        wr_addr    = ADDR_W'(tgt_slot) * ADDR_W'(SEGMENT_DEPTH) + ADDR_W'(tgt_fill);

        case (in_cmd_reg)
            CMD_PUSH: begin
                if (need_new && (count_reg == CNT_W'(MAX_SEGMENTS) || free_reg == '0)) begin
                    status = ST_NO_SLOT;
                end else begin
                    if (need_new) begin
                        free_next[free_slot]           = 1'b0;
                        order_next[SLOT_W'(count_reg)] = free_slot;
                        count_next                     = count_reg + CNT_W'(1);
                    end
                    fill_next[tgt_slot] = tgt_fill + FILL_W'(1);
                    do_write            = 1'b1;
                end
            end
            CMD_POP, CMD_POP_AT: begin
                if (in_cmd_reg == CMD_POP && count_reg == '0) begin
                    status = ST_EMPTY;
                end else if (in_cmd_reg == CMD_POP_AT && !idx_ok) begin
                    status = ST_BAD_INDEX;
                end else begin
                    fill_next[take_slot] = take_fill;
                    if (take_fill == '0) begin
                        // segment emptied: free it and close the gap
                        free_next[take_slot] = 1'b1;
                        for (int i = 0; i < MAX_SEGMENTS - 1; i++) begin
                            if (SLOT_W'(i) >= pos) begin
                                order_next[i] = order_reg[i + 1];
                            end
                        end
                        count_next = count_reg - CNT_W'(1);
                    end
                end
            end
            default: begin
            end
        endcase

        // new top location
        new_last = order_next[SLOT_W'(count_next - CNT_W'(1))];
        new_fill = fill_next[new_last];
        rd_addr  = ADDR_W'(new_last) * ADDR_W'(SEGMENT_DEPTH) + ADDR_W'(new_fill)
                   - ADDR_W'(1);
        if (count_next == '0) begin
            sel = TOP_ZERO;
        end else if (do_write) begin
            sel = TOP_PUSHED;
        end else begin
            sel = TOP_MEM;
        end
    end

    // ---------------- element memory ----------------
    always_ff @(posedge aclk) begin
        if (exec_fire && do_write) begin
            elem_mem[wr_addr] <= push_val;
        end
        if (exec_fire) begin
            rd_data_reg <= elem_mem[rd_addr];
        end
    end

    // ---------------- control state ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg    <= LIMIT_RESET;
            count_reg    <= '0;
            free_reg     <= '1;
            in_valid_reg <= 1'b0;
            p_valid_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
            for (int s = 0; s < MAX_SEGMENTS; s++) begin
                fill_reg[s] <= '0;
            end
        end else begin
            if (cfg_we) begin
                limit_reg <= cfg_wdata;
            end
            if (exec_fire) begin
                count_reg <= count_next;
                free_reg  <= free_next;
                fill_reg  <= fill_next;
            end
            if (in_fire) begin
                in_valid_reg <= 1'b1;
            end else if (exec_fire) begin
                in_valid_reg <= 1'b0;
            end
            if (exec_fire) begin
                p_valid_reg <= 1'b1;
            end else if (out_load) begin
                p_valid_reg <= 1'b0;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // ---------------- payload registers ----------------
    logic signed [VALUE_WIDTH-1:0] top_src;

    always_comb begin
        case (p_sel_reg)
            TOP_PUSHED: top_src = p_pushed_reg;
            TOP_MEM:    top_src = rd_data_reg;
            default:    top_src = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (exec_fire) begin
            order_reg    <= order_next;
            p_status_reg <= status;
            p_empty_reg  <= (count_next == '0);
            p_sel_reg    <= sel;
            p_pushed_reg <= push_val;
        end
        if (in_fire) begin
            in_cmd_reg   <= s_tuser;
            in_value_reg <= s_tdata[DATA_W-1:0];
            in_index_reg <= s_tdata[DATA_W +: INDEX_W];
        end
        if (out_load) begin
            m_status_reg <= p_status_reg;
            m_top_reg    <= DATA_W'(top_src);
            m_empty_reg  <= p_empty_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, m_empty_reg, m_top_reg, m_status_reg};

endmodule

// ----- rtl/sstk_checker.sv -----
// ----------------------------------------------------------------------------
// sstk_port_props
// Port-level checks on the result channel of the segmented stack core.
// ----------------------------------------------------------------------------
module sstk_port_props
    import sstk_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    logic [STATUS_W-1:0] st;
    logic                empty;
    logic [DATA_W-1:0]   top;

    assign st    = m_tdata[STATUS_W-1:0];
    assign top   = m_tdata[M_TOP_LSB +: DATA_W];
    assign empty = m_tdata[M_EMPTY_BIT];

    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_empty_top: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && empty |-> top == '0)
        else $error("empty stack with nonzero top");

    a_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && st == ST_EMPTY |-> empty)
        else $error("pop on empty but stack not empty");

    a_no_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && st == ST_NO_SLOT |-> !empty)
        else $error("no free segment reported on empty stack");

endmodule

bind segmented_stack_with_pop_at_core sstk_port_props u_sstk_port_props (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- sim/sstk_checker.sv -----
// ----------------------------------------------------------------------------
// sstk_checker
// Watches both streams of the segmented stack core, keeps its own copy of the
// segment table and element memory in step with every accepted command, and
// compares each reply field by field against the oldest predicted reply.
// ----------------------------------------------------------------------------
module sstk_checker
    import sstk_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,    // [31:0] value, [35:32] segment_index
    input  logic [CMD_W-1:0]     s_tuser,    // [1:0] command

    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,    // [1:0] status, [33:2] top_value,
                                             // [34] is_empty

    input  logic                 cfg_we,
    input  logic [CFG_W-1:0]     cfg_wdata,

    output int                   mismatch_count,
    output int                   replies_open
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_SLOTS  = 16;
    localparam int SLOT_DEPTH = 16;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [DATA_W-1:0]   top_value;
        logic                is_empty;
    } stack_reply_t;

    stack_reply_t         replies_due [$];

    logic [DATA_W-1:0]    elem_mem    [NUM_SLOTS*SLOT_DEPTH];
    logic [3:0]           slot_of_pos [NUM_SLOTS];
    logic [4:0]           slot_fill   [NUM_SLOTS];
    int unsigned          seg_count;
    logic [NUM_SLOTS-1:0] free_slots;
    logic [CFG_W-1:0]     seg_limit;

    // drop one value from the segment at logical position pos
    function automatic void take_value(int unsigned pos);
        int unsigned slot;
        int unsigned i;
        slot = slot_of_pos[pos];
        if (slot_fill[slot] != 0)
            slot_fill[slot] = slot_fill[slot] - 1'b1;
        if (slot_fill[slot] == 0) begin
            // segment gone: free its slot, close the gap in the order
            free_slots[slot] = 1'b1;
            for (i = pos; i + 1 < seg_count; i++)
                slot_of_pos[i] = slot_of_pos[i + 1];
            seg_count--;
        end
    endfunction

    function automatic stack_reply_t apply_access(logic [CMD_W-1:0] cmd,
                                                  logic [DATA_W-1:0] value,
                                                  logic [INDEX_W-1:0] index);
        stack_reply_t reply;
        int unsigned  lim;
        int unsigned  slot;
        logic         open_seg;
        reply.status    = ST_OK;
        reply.top_value = '0;
        lim = (seg_limit == 0) ? 1 : seg_limit;
        if (lim > SLOT_DEPTH)
            lim = SLOT_DEPTH;

        case (cmd)
            CMD_PUSH: begin
                open_seg = 1'b1;
                if (seg_count != 0)
                    open_seg = (slot_fill[slot_of_pos[seg_count - 1]] >= lim);
                if (open_seg && (seg_count >= NUM_SLOTS || free_slots == '0)) begin
                    reply.status = ST_NO_SLOT;
                end else begin
                    if (open_seg) begin
                        slot = 0;
                        while (!free_slots[slot])
                            slot++;
                        free_slots[slot]       = 1'b0;
                        slot_fill[slot]        = '0;
                        slot_of_pos[seg_count] = slot[3:0];
                        seg_count++;
                    end
                    slot = slot_of_pos[seg_count - 1];
                    elem_mem[slot*SLOT_DEPTH + slot_fill[slot]] = value;
                    slot_fill[slot] = slot_fill[slot] + 1'b1;
                end
            end
            CMD_POP: begin
                if (seg_count == 0)
                    reply.status = ST_EMPTY;
                else
                    take_value(seg_count - 1);
            end
            CMD_POP_AT: begin
                if (index >= seg_count)
                    reply.status = ST_BAD_INDEX;
                else
                    take_value(index);
            end
            default: ;
        endcase

        if (seg_count != 0) begin
            slot = slot_of_pos[seg_count - 1];
            if (slot_fill[slot] != 0)
                reply.top_value = elem_mem[slot*SLOT_DEPTH + slot_fill[slot] - 1];
        end
        reply.is_empty = (seg_count == 0);
        return reply;
    endfunction

    always @(posedge aclk) begin : watch
        stack_reply_t got;
        stack_reply_t want;
        stack_reply_t due;
        int           k;
        if (!aresetn) begin
            replies_due.delete();
            seg_count  = 0;
            free_slots = '1;
            seg_limit  = LIMIT_RESET;
            for (k = 0; k < NUM_SLOTS; k++) begin
                slot_fill[k]   = '0;
                slot_of_pos[k] = '0;
            end
        end else begin
            // check before predicting: a new command always queues behind
            if (m_tvalid && m_tready) begin
                got.status    = m_tdata[STATUS_W-1:0];
                got.top_value = m_tdata[M_TOP_LSB +: DATA_W];
                got.is_empty  = m_tdata[M_EMPTY_BIT];
                if (replies_due.size() == 0) begin
                    mismatch_count = mismatch_count + 1;
                    if (mismatch_count <= 10)
                        $display("%0t: unexpected reply status %0d top %h empty %0d",
                                 $time, got.status, got.top_value, got.is_empty);
                end else begin
                    want = replies_due.pop_front();
                    if (got.status !== want.status || got.top_value !== want.top_value
                        || got.is_empty !== want.is_empty) begin
                        mismatch_count = mismatch_count + 1;
                        if (mismatch_count <= 10) begin
                            $display("%0t: reply mismatch: expected status %0d top %h empty %0d",
                                     $time, want.status, want.top_value, want.is_empty);
                            $display("%0t:                      got status %0d top %h empty %0d",
                                     $time, got.status, got.top_value, got.is_empty);
                        end
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                due = apply_access(s_tuser, s_tdata[DATA_W-1:0],
                                   s_tdata[DATA_W +: INDEX_W]);
                replies_due = {replies_due, due};
            end
            if (cfg_we)
                seg_limit = cfg_wdata;
        end
        replies_open <= replies_due.size();
    end

endmodule

// ----- sim/tb_segmented_stack_with_pop_at_core.sv -----
// ----------------------------------------------------------------------------
// tb_segmented_stack_with_pop_at_core
// Drives push, pop, pop-at and the spare command into the segmented stack
// core across a series of segment limits, with random gaps and stalls on both
// streams and long output back-pressure; sstk_checker judges every reply.
// ----------------------------------------------------------------------------
module tb_segmented_stack_with_pop_at_core;
    timeunit 1ns;
    timeprecision 1ps;

    import sstk_pkg::*;

    // spare command code: the core changes nothing and reports the current top
    localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_PHASES = 9;
    localparam int PHASE_ITEMS   = 50;
    localparam int CALM_PHASE    = 4;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic [CMD_W-1:0]     s_tuser   = CMD_PUSH;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_we    = 1'b0;
    logic [CFG_W-1:0]     cfg_wdata = '0;
    logic                 calm      = 1'b0;

    int mismatch_count;
    int replies_open;
    int cycle_count = 0;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    segmented_stack_with_pop_at_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    sstk_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .mismatch_count (mismatch_count),
        .replies_open   (replies_open)
    );

    // one transaction on the command stream, with a random gap ahead of it
    task automatic offer_command(input logic [CMD_W-1:0]   cmd,
                                 input logic [DATA_W-1:0]  value,
                                 input logic [INDEX_W-1:0] index);
        while (!calm && $urandom_range(99) < 27) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {{S_PAD_W{1'b0}}, index, value};
        do @(posedge aclk); while (!s_tready);
    endtask

    // limit changes only with the core drained
    task automatic load_limit(input logic [CFG_W-1:0] lim);
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (replies_open != 0);
        repeat (4) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= lim;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    task automatic random_command(input int push_pct);
        int                 roll;
        logic [CMD_W-1:0]   cmd;
        logic [DATA_W-1:0]  value;
        logic [INDEX_W-1:0] index;
        roll = $urandom_range(99);
        if (roll < push_pct)
            cmd = CMD_PUSH;
        else if (roll < push_pct + 4)
            cmd = CMD_NOP;
        else if (roll[0])
            cmd = CMD_POP;
        else
            cmd = CMD_POP_AT;
        case ($urandom_range(9))
            0:       value = 32'h8000_0000;
            1:       value = 32'h7FFF_FFFF;
            default: value = $urandom();
        endcase
        // low positions are where pop-at mostly hits live segments
        if ($urandom_range(9) < 6)
            index = INDEX_W'($urandom_range(3));
        else
            index = INDEX_W'($urandom_range(15));
        offer_command(cmd, value, index);
    endtask

    initial begin : stimulus
        int               p;
        int               k;
        int               push_pct;
        logic [CFG_W-1:0] lim;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty stack, reset limit of five
        offer_command(CMD_POP,    '0, '0);
        offer_command(CMD_POP_AT, '0, 4'd0);
        offer_command(CMD_NOP,    '0, '0);
        offer_command(CMD_PUSH,   32'h8000_0000, 4'hF);
        offer_command(CMD_PUSH,   32'h7FFF_FFFF, '0);
        offer_command(CMD_PUSH,   32'h0000_0000, '0);
        offer_command(CMD_PUSH,   32'hFFFF_FFFF, '0);
        offer_command(CMD_PUSH,   32'h1234_5678, '0);
        offer_command(CMD_PUSH,   32'h0F0F_0F0F, '0);  // opens a second segment
        offer_command(CMD_POP_AT, '0, 4'd2);            // past the last segment
        offer_command(CMD_POP_AT, '0, 4'hF);
        offer_command(CMD_POP_AT, '0, 4'd0);
        offer_command(CMD_NOP,    '0, '0);
        offer_command(CMD_POP,    '0, '0);              // drops the second segment

        // zero acts as one; the held segment is now over the limit
        load_limit(5'd0);
        for (k = 0; k < 16; k++)
            offer_command(CMD_PUSH, $urandom(), '0);    // last one finds no slot

        for (p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0:       lim = 5'd3;
                1:       lim = 5'd1;
                2:       lim = 5'd31;
                3:       lim = 5'd2;
                4:       lim = 5'd16;
                5:       lim = 5'd17;
                6:       lim = 5'd0;
                7:       lim = 5'd7;
                default: lim = CFG_W'($urandom_range(31));
            endcase
            push_pct = (p == CALM_PHASE) ? 80 : (p % 2) ? 72 : 38;
            load_limit(lim);
            calm <= (p == CALM_PHASE);
            for (k = 0; k < PHASE_ITEMS; k++)
                random_command(push_pct);
        end

        s_tvalid <= 1'b0;
        calm     <= 1'b0;
        do @(posedge aclk); while (replies_open != 0);
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0 && replies_open == 0)
            $display("tb_segmented_stack_with_pop_at_core passed");
        else
            $display("tb_segmented_stack_with_pop_at_core failed");
        $finish;
    end

    // result side: random stalls, plus two long hold-offs so the core backs up
    initial begin : result_sink
        int taken;
        int choked_at;
        taken     = 0;
        choked_at = -1;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready)
                taken++;
            if (taken != choked_at && (taken == 60 || taken == 300)) begin
                choked_at = taken;
                m_tready <= 1'b0;
                repeat (90) @(posedge aclk);
            end
            m_tready <= calm || ($urandom_range(99) >= 27);
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_segmented_stack_with_pop_at_core failed");
            $finish;
        end
    end

endmodule
